### rtl/dmwbc_pkg.sv
// Shared types and constants of the direct-mapped write-back cache tag core.
package dmwbc_pkg;

    localparam int ENTRIES      = 16;
    localparam int CLUSTER_BITS = 16;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int TAG_W        = CLUSTER_BITS;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] cluster;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  entry_index;
        logic        hit;
        logic        write_back;
        logic [15:0] victim_cluster;
        logic        fill;
        logic        error;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic accept;
        logic load_err;
        logic lookup;
        logic flush_cap;
        logic emit;
        logic flush_next;
    } t_cmd;

    typedef struct packed {
        logic in_flush;
        logic in_access;
        logic in_range;
        logic out_free;
        logic cnt_last;
    } t_stat;

endpackage

### rtl/direct_mapped_writeback_cache_tags_core.sv
// Top level of the direct-mapped write-back cache tag and status core.
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+----------------------
//  in      | input     | i_in_valid/o_in_stall | t_in_beat (kind, cluster)
//  out     | output    | o_out_valid/i_out_stall | t_out_beat (one result)
//
// Read/write: accept, tag RAM lookup, then load output register.
// Out-of-range cluster: accept and load the error result, then emit. Flush:
// capture and emit per entry, paced by the single registered tag RAM read port.
// One item in flight; the next beat is taken while the last result waits.
// Reset (synchronous, active low) clears valid/dirty bits and the output valid.
// A stalled output holds the pending result; the walk or the emit waits on it.
module direct_mapped_writeback_cache_tags_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dmwbc_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dmwbc_pkg::t_out_beat o_out_beat
);

    import dmwbc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dmwbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dmwbc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over a pending beat");

    a_rose_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.emit))
        else $error("output valid without a load");

    a_nonlast_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.last) |->
            (!o_out_beat.hit && !o_out_beat.fill && !o_out_beat.error))
        else $error("non-final beat is not a flush result");

    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.error) |->
            (o_out_beat.last && !o_out_beat.write_back && !o_out_beat.fill))
        else $error("error beat carries access results");

endmodule

### rtl/dmwbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmwbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dmwbc_ctrl.sv
// Controller state machine: sequences lookups, flush walk and result hand-off.
module dmwbc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dmwbc_pkg::t_stat i_stat,
    output dmwbc_pkg::t_cmd  o_cmd
);

    import dmwbc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_READ       = 5'b00010,
        S_EMIT       = 5'b00100,
        S_FLUSH_READ = 5'b01000,
        S_FLUSH_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_stat.in_flush) begin
                        n_state = S_FLUSH_READ;
                    end else if (i_stat.in_access) begin
                        if (i_stat.in_range) begin
                            n_state = S_READ;
                        end else begin
                            cmd.load_err = 1'b1;
                            n_state      = S_EMIT;
                        end
                    end
                end
            end
            S_READ: begin
                cmd.lookup = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_FLUSH_READ: begin
                cmd.flush_cap = 1'b1;
                n_state       = S_FLUSH_EMIT;
            end
            S_FLUSH_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (i_stat.cnt_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.flush_next = 1'b1;
                        n_state        = S_FLUSH_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

### rtl/dmwbc_dp.sv
// Datapath: tag RAM, valid/dirty bits, flush counter, result and output registers.
module dmwbc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dmwbc_pkg::t_in_beat  i_in_beat,
    input  dmwbc_pkg::t_cmd      i_cmd,
    output dmwbc_pkg::t_stat     o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dmwbc_pkg::t_out_beat o_out_beat
);

    import dmwbc_pkg::*;

    logic [TAG_W-1:0]   r_cluster;
    logic               r_is_write;
    logic [IDX_W-1:0]   r_cnt;
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_dirty;
    t_out_beat          r_res;
    t_out_beat          r_out;
    logic               r_out_valid;

    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] acc_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [TAG_W-1:0] tag_rd;
    logic             hit;
    logic             wb_acc;
    logic             wb_fl;
    logic             tag_we;
    t_stat            stat;

    assign in_idx  = i_in_beat.cluster[IDX_W-1:0];
    assign acc_idx = r_cluster[IDX_W-1:0];

    assign stat.in_flush  = (i_in_beat.kind == KIND_FLUSH);
    assign stat.in_access = (i_in_beat.kind == KIND_READ) || (i_in_beat.kind == KIND_WRITE);
    assign stat.in_range  = ((i_in_beat.cluster >> CLUSTER_BITS) == '0);
    assign stat.out_free  = !r_out_valid || !i_out_stall;
    assign stat.cnt_last  = (r_cnt == IDX_W'(ENTRIES - 1));
    assign o_stat         = stat;

    // flush reads the next entry while the current beat waits
    assign rd_addr = i_cmd.accept ? (stat.in_flush ? '0 : in_idx) : r_cnt + IDX_W'(1);

    assign hit    = r_valid[acc_idx] && (tag_rd == r_cluster);
    assign wb_acc = !hit && r_dirty[acc_idx];
    assign wb_fl  = r_dirty[r_cnt];
    assign tag_we = i_cmd.lookup && !hit;

    dmwbc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (acc_idx),
        .i_wdata (r_cluster),
        .i_raddr (rd_addr),
        .o_rdata (tag_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cluster  <= i_in_beat.cluster[TAG_W-1:0];
            r_is_write <= (i_in_beat.kind == KIND_WRITE);
            if (stat.in_flush) begin
                r_cnt <= '0;
            end
        end else if (i_cmd.flush_next) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end

        if (i_cmd.load_err) begin
            r_res.entry_index    <= '0;
            r_res.hit            <= 1'b0;
            r_res.write_back     <= 1'b0;
            r_res.victim_cluster <= '0;
            r_res.fill           <= 1'b0;
            r_res.error          <= 1'b1;
            r_res.last           <= 1'b1;
        end else if (i_cmd.lookup) begin
            r_res.entry_index    <= 4'(acc_idx);
            r_res.hit            <= hit;
            r_res.write_back     <= wb_acc;
            r_res.victim_cluster <= wb_acc ? 16'(tag_rd) : '0;
            r_res.fill           <= !hit;
            r_res.error          <= 1'b0;
            r_res.last           <= 1'b1;
        end else if (i_cmd.flush_cap) begin
            r_res.entry_index    <= 4'(r_cnt);
            r_res.hit            <= 1'b0;
            r_res.write_back     <= wb_fl;
            r_res.victim_cluster <= wb_fl ? 16'(tag_rd) : '0;
            r_res.fill           <= 1'b0;
            r_res.error          <= 1'b0;
            r_res.last           <= stat.cnt_last;
        end

        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_dirty     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.lookup) begin
                r_valid[acc_idx] <= 1'b1;
                r_dirty[acc_idx] <= r_is_write || (hit && r_dirty[acc_idx]);
            end else if (i_cmd.flush_cap) begin
                r_valid[r_cnt] <= 1'b0;
                r_dirty[r_cnt] <= 1'b0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

### sim/cache_tag_checker.sv
`timescale 1ns / 1ps
// Tracks cache tag state from accepted requests and checks every result beat against it.
module cache_tag_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  dmwbc_pkg::t_in_beat  i_in_beat,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  dmwbc_pkg::t_out_beat i_out_beat,
    output int                   o_errors,
    output int                   o_pending
);

    import dmwbc_pkg::*;

    logic [TAG_W-1:0]   tag_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_bits;
    logic [ENTRIES-1:0] dirty_bits;
    t_out_beat          awaited_results [$];
    int                 errors = 0;

    function automatic string show_beat(input t_out_beat b);
        return $sformatf("idx=%0d hit=%b wb=%b victim=%h fill=%b err=%b last=%b",
                         b.entry_index, b.hit, b.write_back, b.victim_cluster,
                         b.fill, b.error, b.last);
    endfunction

    task automatic predict_tag_results(input t_in_beat beat);
        t_out_beat        res;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tag;
        logic             hit;
        res = '0;
        if (beat.kind == KIND_FLUSH) begin
            for (int e = 0; e < ENTRIES; e++) begin
                res                = '0;
                res.entry_index    = 4'(e);
                res.write_back     = dirty_bits[e];
                res.victim_cluster = dirty_bits[e] ? tag_mem[e] : '0;
                res.last           = (e == ENTRIES - 1);
                awaited_results.push_back(res);
            end
            valid_bits = '0;
            dirty_bits = '0;
        end else if (beat.kind == KIND_READ || beat.kind == KIND_WRITE) begin
            if ((64'(beat.cluster) >> CLUSTER_BITS) != 0) begin
                res.error = 1'b1;
            end else begin
                idx             = beat.cluster[IDX_W-1:0];
                tag             = beat.cluster[TAG_W-1:0];
                hit             = valid_bits[idx] && (tag_mem[idx] == tag);
                res.entry_index = 4'(idx);
                res.hit         = hit;
                if (!hit) begin
                    res.write_back     = dirty_bits[idx];
                    res.victim_cluster = dirty_bits[idx] ? tag_mem[idx] : '0;
                    res.fill           = 1'b1;
                    tag_mem[idx]       = tag;
                    valid_bits[idx]    = 1'b1;
                    dirty_bits[idx]    = 1'b0;
                end
                if (beat.kind == KIND_WRITE) begin
                    dirty_bits[idx] = 1'b1;
                end
            end
            res.last = 1'b1;
            awaited_results.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_beat want;
        if (!i_rst_n) begin
            valid_bits = '0;
            dirty_bits = '0;
            for (int e = 0; e < ENTRIES; e++) begin
                tag_mem[e] = '0;
            end
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result beat: got %s", $time,
                             show_beat(i_out_beat));
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_beat !== want) begin
                        $display("%0t: result mismatch: expected %s, got %s", $time,
                                 show_beat(want), show_beat(i_out_beat));
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_tag_results(i_in_beat);
            end
        end
        o_pending <= awaited_results.size();
        o_errors  <= errors;
    end

endmodule

### sim/direct_mapped_writeback_cache_tags_core_tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, request and stall generation, and the final verdict.
module direct_mapped_writeback_cache_tags_core_tb;
    import dmwbc_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         SETTLE_WAIT  = 2 * ENTRIES + 8;
    localparam int         HOLD_CYCLES  = 150;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_start    = 1'b0;
    bit hold_done     = 1'b0;

    direct_mapped_writeback_cache_tags_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    cache_tag_checker tag_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_beat  (out_beat),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_start && !hold_done && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
                if (hold_left == 0) begin
                    hold_done = 1'b1;
                end
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycles, pending);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_beat(input logic [1:0] beat_kind, input logic [31:0] beat_cluster);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= {beat_kind, beat_cluster};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_random_beat(output bit counted);
        int          pick;
        logic [1:0]  kind_sel;
        logic [31:0] cl;
        pick     = $urandom_range(99);
        kind_sel = $urandom_range(1) ? KIND_WRITE : KIND_READ;
        cl       = $urandom;
        counted  = 1'b1;
        if (pick < 55) begin
            cl = {16'h0, 12'($urandom_range(3)), 4'($urandom_range(15))};
        end else if (pick < 80) begin
            cl = {16'h0, 16'($urandom)};
        end else if (pick < 88) begin
            cl[16 + $urandom_range(15)] = 1'b1;
        end else if (pick < 95) begin
            kind_sel = KIND_FLUSH;
        end else begin
            kind_sel = KIND_UNUSED;
            counted  = 1'b0;
        end
        send_beat(kind_sel, cl);
    endtask

    task automatic run_random(input int count);
        int sent;
        bit counted;
        sent = 0;
        while (sent < count) begin
            send_random_beat(counted);
            if (counted) begin
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(KIND_READ,   32'h0000_0000);
        send_beat(KIND_READ,   32'h0000_0000);
        send_beat(KIND_WRITE,  32'h0000_0000);
        send_beat(KIND_READ,   32'h0000_0010);
        send_beat(KIND_WRITE,  32'h0000_FFFF);
        send_beat(KIND_WRITE,  32'h0000_FFFF);
        send_beat(KIND_READ,   32'h0000_000F);
        send_beat(KIND_WRITE,  32'h0000_8001);
        send_beat(KIND_READ,   32'h0001_0000);
        send_beat(KIND_WRITE,  32'hFFFF_FFFF);
        send_beat(KIND_WRITE,  32'h8000_0000);
        send_beat(KIND_UNUSED, 32'h0000_0001);
        send_beat(KIND_WRITE,  32'h0000_0002);
        send_beat(KIND_FLUSH,  32'h0000_0000);
        send_beat(KIND_FLUSH,  32'hFFFF_FFFF);
        send_beat(KIND_READ,   32'h0000_8001);
        send_beat(KIND_WRITE,  32'h0000_FFFE);
        send_beat(KIND_READ,   32'h0000_FFFE);
        send_beat(KIND_READ,   32'h0000_7FFE);
        wait_results_done();

        // output held off for a long stretch while requests keep coming
        hold_start = 1'b1;
        run_random(40);
        wait_results_done();

        send_idle_pct = 70;
        stall_pct     = 0;
        run_random(55);
        wait_results_done();

        send_idle_pct = 0;
        stall_pct     = 70;
        run_random(55);
        wait_results_done();

        send_idle_pct = 33;
        stall_pct     = 33;
        run_random(55);
        wait_results_done();

        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(45);
        wait_results_done();

        repeat (SETTLE_WAIT) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dmwbc_pkg.sv
rtl/dmwbc_ram.sv
rtl/dmwbc_ctrl.sv
rtl/dmwbc_dp.sv
rtl/direct_mapped_writeback_cache_tags_core.sv
sim/cache_tag_checker.sv
sim/direct_mapped_writeback_cache_tags_core_tb.sv
